// ===== hw/rtl/sdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// Saturating divider package
// Word types, stage state and fixed sizes shared by the divider files.
// ----------------------------------------------------------------------------
`default_nettype none

package sdiv_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned NumSteps = 2 * WordBits;

  typedef logic [WordBits-1:0]   word_t;
  typedef logic [2*WordBits-1:0] dword_t;

  typedef struct packed {
    word_t dividend_low;
    word_t dividend_high;
    logic  use_high;
    word_t divisor;
  } req_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
  } rsp_t;

  // Partial remainder, dividend bits still to come with quotient bits shifted
  // in behind them, and the divisor that travels with the word.
  typedef struct packed {
    word_t  rem;
    dword_t acc;
    word_t  divisor;
  } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdiv_if.sv =====
// ----------------------------------------------------------------------------
// Saturating divider stream interface
// Valid/ready channel that carries one word of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdiv_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/saturating_64_by_32_divider.sv =====
// ----------------------------------------------------------------------------
// Saturating 64 by 32 divider
// Unsigned divider with a quotient clamped to 32 bits and an exact remainder.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req_i    in   dividend_low, dividend_high, use_high, divisor
// rsp_o    out  quotient, remainder
//
// A word is accepted every cycle unless a stalled output has filled the chain;
// the first of 64 division cells loads it at the edge that accepts it, one
// quotient bit per cell, and the output register follows the last cell.
// Reset clears every valid flag in the chain and the output valid flag.
// Each cell passes its word on when the next one is empty or moving, so a
// stalled output fills the chain gap by gap before req_i.ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_64_by_32_divider (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdiv_if.sink      req_i,
  sdiv_if.source    rsp_o
);

  import sdiv_pkg::*;

  logic   [NumSteps:0] valid;
  logic   [NumSteps:0] ready;
  stage_t              data [NumSteps+1];

  logic   out_valid_q;
  rsp_t   out_data_q;
  rsp_t   out_data_d;

  assign data[0] = {word_t'(0),
                    req_i.data.use_high ? req_i.data.dividend_high : word_t'(0),
                    req_i.data.dividend_low,
                    req_i.data.divisor};

  assign valid[0]    = req_i.valid;
  assign req_i.ready = ready[0];

  for (genvar i = 0; i < NumSteps; i++) begin : g_cell
    sdiv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid[i]),
      .up_data_i  (data[i]),
      .up_ready_o (ready[i]),
      .dn_valid_o (valid[i+1]),
      .dn_data_o  (data[i+1]),
      .dn_ready_i (ready[i+1])
    );
  end

  assign ready[NumSteps] = !out_valid_q || rsp_o.ready;

  always_comb begin
    if (data[NumSteps].divisor == '0) begin
      out_data_d.quotient  = '1;
      out_data_d.remainder = '0;
    end else begin
      out_data_d.quotient  = (|data[NumSteps].acc[2*WordBits-1:WordBits]) ? '1
                             : data[NumSteps].acc[WordBits-1:0];
      out_data_d.remainder = data[NumSteps].rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready[NumSteps]) begin
      out_valid_q <= valid[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[NumSteps] && valid[NumSteps]) begin
      out_data_q <= out_data_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sdiv_cell.sv =====
// ----------------------------------------------------------------------------
// Saturating divider cell
// One restoring division step on a registered stage, with its own handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sdiv_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             up_valid_i,
  input  wire sdiv_pkg::stage_t up_data_i,
  output logic                  up_ready_o,
  output logic                  dn_valid_o,
  output sdiv_pkg::stage_t      dn_data_o,
  input  wire logic             dn_ready_i
);

  import sdiv_pkg::*;

  logic                valid_q;
  stage_t              data_q;
  stage_t              data_d;
  logic [WordBits:0]   trial;
  logic [WordBits:0]   diff;
  logic                fits;

  always_comb begin
    trial  = {up_data_i.rem, up_data_i.acc[2*WordBits-1]};
    diff   = trial - {1'b0, up_data_i.divisor};
    fits   = trial >= {1'b0, up_data_i.divisor};
    data_d = up_data_i;
    data_d.rem = fits ? diff[WordBits-1:0] : trial[WordBits-1:0];
    data_d.acc = {up_data_i.acc[2*WordBits-2:0], fits};
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire
